@@ hdl/ultrasonic_height_lift_control_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the lift height controller
// Short forms for clocked assertions with a synchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_HEIGHT_LIFT_CONTROL_MACROS_SVH
`define ULTRASONIC_HEIGHT_LIFT_CONTROL_MACROS_SVH

// property must hold at every clock edge outside reset
`define UHLC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define UHLC_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

@@ hdl/uhlc_pkg.sv @@
// ----------------------------------------------------------------------------
// uhlc_pkg
// Types, widths and constants shared by the lift height controller.
// ----------------------------------------------------------------------------
package uhlc_pkg;

   // field widths
   localparam int ECHO_W      = 16;
   localparam int HEIGHT_W    = 14;
   localparam int GAIN_W      = 16;
   localparam int SF_W        = 10;
   localparam int FILT_W      = 32;
   localparam int FRAC_W      = 16;
   localparam int DIFF_W      = 34;  // echo<<16 minus filtered value, signed
   localparam int ACC_W       = 50;  // accumulator of the shared unit
   localparam int MLT_W       = 22;  // multiplier register width
   localparam int COUNT_W     = 5;

   // shift-add steps per pass, one per multiplier bit
   localparam int FILT_STEPS  = 16;  // filter gain
   localparam int SF_STEPS    = 10;  // sound factor
   localparam int RECIP_STEPS = 22;  // product after the pre-shift

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] REG_FILTER_GAIN    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SOUND_FACTOR   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LOWEST_HEIGHT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HIGHEST_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FIRST_PRESET   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SECOND_PRESET  = 3'd5;

   // register reset values
   localparam logic [GAIN_W-1:0]   GAIN_RESET     = 16'd6554;
   localparam logic [SF_W-1:0]     SF_RESET       = 10'd347;
   localparam logic [HEIGHT_W-1:0] LOWEST_RESET   = 14'd500;
   localparam logic [HEIGHT_W-1:0] HIGHEST_RESET  = 14'd750;
   localparam logic [HEIGHT_W-1:0] FIRST_RESET    = 14'd550;
   localparam logic [HEIGHT_W-1:0] SECOND_RESET   = 14'd655;

   // height conversion
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET   = 14'd550;
   localparam int                  QUOT_W         = 16;
   localparam logic [QUOT_W-1:0]   HEIGHT_MAX     = 16'd16383;
   localparam int                  DIVISOR        = 2000;
   // x / 2000 == ((x >> 4) * ceil(2^29 / 125)) >> 29 for every x below 2^26
   localparam int                  RECIP_PRESHIFT = 4;
   localparam int                  RECIP_SHIFT    = 29;
   localparam logic [ACC_W-1:0]    RECIP_125      = ACC_W'(4294968);

   // item kinds
   localparam logic [1:0] MODE_ECHO   = 2'd0;
   localparam logic [1:0] MODE_GOTO   = 2'd1;
   localparam logic [1:0] MODE_PRESET = 2'd2;
   localparam logic [1:0] MODE_MANUAL = 2'd3;

   // manual direction codes
   localparam logic [1:0] DIR_UP   = 2'b01;
   localparam logic [1:0] DIR_DOWN = 2'b11;

   typedef logic [HEIGHT_W-1:0] height_type;
   typedef height_type preset_array_type [4];

   typedef struct packed {
      logic               start;
      logic [COUNT_W-1:0] last;   // index of the final step
   } arith_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } arith_stat_type;

endpackage

@@ hdl/uhlc_csr_regs.sv @@
// ----------------------------------------------------------------------------
// uhlc_csr_regs
// Configuration registers: filter gain, sound factor and four height presets.
// ----------------------------------------------------------------------------
module uhlc_csr_regs (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write,
   input  logic [uhlc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [uhlc_pkg::CSR_DATA_W-1:0]  csr_data,
   output logic [uhlc_pkg::GAIN_W-1:0]      filter_gain,
   output logic [uhlc_pkg::SF_W-1:0]        sound_factor,
   output uhlc_pkg::preset_array_type       presets
);
   import uhlc_pkg::*;

   logic [GAIN_W-1:0] gain_ff;
   logic [SF_W-1:0]   sf_ff;
   preset_array_type  preset_ff;

   // register writes, out-of-range indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff      <= GAIN_RESET;
         sf_ff        <= SF_RESET;
         preset_ff[0] <= LOWEST_RESET;
         preset_ff[1] <= HIGHEST_RESET;
         preset_ff[2] <= FIRST_RESET;
         preset_ff[3] <= SECOND_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_FILTER_GAIN:    gain_ff      <= csr_data[GAIN_W-1:0];
            REG_SOUND_FACTOR:   sf_ff        <= csr_data[SF_W-1:0];
            REG_LOWEST_HEIGHT:  preset_ff[0] <= csr_data[HEIGHT_W-1:0];
            REG_HIGHEST_HEIGHT: preset_ff[1] <= csr_data[HEIGHT_W-1:0];
            REG_FIRST_PRESET:   preset_ff[2] <= csr_data[HEIGHT_W-1:0];
            REG_SECOND_PRESET:  preset_ff[3] <= csr_data[HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   assign filter_gain  = gain_ff;
   assign sound_factor = sf_ff;
   assign presets      = preset_ff;

endmodule

@@ hdl/uhlc_arith.sv @@
// ----------------------------------------------------------------------------
// uhlc_arith
// Shared shift-add multiplier with accumulator preload, built around one
// accumulator adder, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module uhlc_arith (
   input  logic                          clock,
   input  logic                          reset,
   input  uhlc_pkg::arith_cmd_type       cmd,
   input  logic [uhlc_pkg::ACC_W-1:0]    operand,     // multiplicand, two's complement
   input  logic [uhlc_pkg::ACC_W-1:0]    preload,     // accumulator start
   input  logic [uhlc_pkg::MLT_W-1:0]    multiplier,
   output uhlc_pkg::arith_stat_type      stat,
   output logic [uhlc_pkg::ACC_W-1:0]    acc
);
   import uhlc_pkg::*;

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] last_ff;
   logic [ACC_W-1:0]   acc_ff;
   logic [ACC_W-1:0]   opd_ff;
   logic [MLT_W-1:0]   mlt_ff;

   logic [ACC_W-1:0]   addend;
   logic [ACC_W-1:0]   sum;

   // the one adder: add the multiplicand when the current multiplier bit is set
   always_comb begin
      addend = mlt_ff[0] ? opd_ff : '0;
      sum    = acc_ff + addend;
   end

   // control
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         busy_in = 1'b1;
      end else if (busy_ff && count_ff == last_ff) begin
         busy_in = 1'b0;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         count_ff <= '0;
         last_ff  <= cmd.last;
         acc_ff   <= preload;
         opd_ff   <= operand;
         mlt_ff   <= multiplier;
      end else if (busy_ff) begin
         count_ff <= count_ff + 1'b1;
         acc_ff   <= sum;
         opd_ff   <= opd_ff << 1;
         mlt_ff   <= mlt_ff >> 1;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign acc       = acc_ff;

endmodule

@@ hdl/ultrasonic_height_lift_control.sv @@
// ----------------------------------------------------------------------------
// ultrasonic_height_lift_control
// Lift height controller: echo filter, height conversion and motor drive.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  input stream, one transaction per echo sample or command; the kind
//          travels in req_tuser. Accepted only while the block is idle.
//   rsp_*  one result transaction per input: motor drive, height, seek flag.
//   csr_*  register writes, always ready; write only while idle, not checked.
// Sequence: a command (go to height, go to preset, manual) goes from idle
//   straight to evaluation and a registered result. An echo sample first
//   runs three passes of the shared multiplier (16-step filter, 10-step
//   sound factor, 22-step reciprocal of 2000), each a start state and a
//   wait state for its done strobe, then evaluation.
// Flow: one item at a time. The next item is taken as soon as the result
//   sits in the output register, so a slow receiver does not hold off the
//   next item, only the delivery of its result; that item then waits before
//   its result.
// Reset: registers take their default values, the filter is cleared, height
//   and goal read 550 mm, no seek, manual drive stop.
// ----------------------------------------------------------------------------
module ultrasonic_height_lift_control (
   input  logic                             clock,
   input  logic                             reset,
   // input stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // echo_time[15:0], target_height[29:16], preset_index[31:30],
   // direction[33:32], zero pad [39:34]
   input  logic [39:0]                      req_tdata,
   // mode[1:0]
   input  logic [1:0]                       req_tuser,
   // result stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // motor_up[0], motor_down[1], height_mm[15:2], seeking[16], zero pad [23:17]
   output logic [23:0]                      rsp_tdata,
   // configuration
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [uhlc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [uhlc_pkg::CSR_DATA_W-1:0]  csr_data
);
   import uhlc_pkg::*;

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_FILT_GO   = 3'd1;
   localparam logic [2:0] S_FILT_WAIT = 3'd2;
   localparam logic [2:0] S_HMUL_GO   = 3'd3;
   localparam logic [2:0] S_HMUL_WAIT = 3'd4;
   localparam logic [2:0] S_HDIV_GO   = 3'd5;
   localparam logic [2:0] S_HDIV_WAIT = 3'd6;
   localparam logic [2:0] S_EVAL      = 3'd7;

   // input fields
   logic [1:0]          in_mode;
   logic [ECHO_W-1:0]   in_echo;
   logic [HEIGHT_W-1:0] in_target;
   logic [1:0]          in_preset;
   logic [1:0]          in_dir;

   assign in_mode   = req_tuser;
   assign in_echo   = req_tdata[15:0];
   assign in_target = req_tdata[29:16];
   assign in_preset = req_tdata[31:30];
   assign in_dir    = req_tdata[33:32];

   // configuration registers
   logic [GAIN_W-1:0] filter_gain;
   logic [SF_W-1:0]   sound_factor;
   preset_array_type  presets;

   assign csr_ready = 1'b1;

   uhlc_csr_regs u_csr_regs (
      .clock        (clock),
      .reset        (reset),
      .csr_write    (csr_valid && csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .filter_gain  (filter_gain),
      .sound_factor (sound_factor),
      .presets      (presets)
   );

   // state
   logic [2:0]          state_ff, state_in;
   logic [ECHO_W-1:0]   echo_ff;
   logic [FILT_W-1:0]   filt_ff;
   logic [HEIGHT_W-1:0] meas_ff;
   logic [HEIGHT_W-1:0] goal_ff;
   logic                seek_ff;
   logic [1:0]          manual_ff;
   logic                rsp_valid_ff;
   logic [23:0]         rsp_data_ff;

   logic                in_fire;
   logic                out_free;

   assign req_tready = (state_ff == S_IDLE);
   assign in_fire    = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // shared arithmetic unit
   arith_cmd_type         arith_cmd;
   arith_stat_type        arith_stat;
   logic [ACC_W-1:0]      arith_operand;
   logic [ACC_W-1:0]      arith_preload;
   logic [MLT_W-1:0]      arith_mult;
   logic [ACC_W-1:0]      arith_acc;
   logic [QUOT_W-1:0]     height_quot;
   logic signed [DIFF_W-1:0] filt_diff;

   // sample in Q16.16 minus filtered value
   assign filt_diff = DIFF_W'({echo_ff, {FRAC_W{1'b0}}}) - DIFF_W'(filt_ff);

   // height in mm from the reciprocal product
   assign height_quot = arith_acc[RECIP_SHIFT +: QUOT_W];

   always_comb begin
      arith_cmd.start = 1'b0;
      arith_cmd.last  = '0;
      arith_operand   = '0;
      arith_preload   = '0;
      arith_mult      = '0;
      case (state_ff)
         S_FILT_GO: begin
            // floor((filt<<16 + diff*gain) / 2^16) is the new filter value
            arith_cmd.start = 1'b1;
            arith_cmd.last  = COUNT_W'(FILT_STEPS - 1);
            arith_operand   = {{(ACC_W-DIFF_W){filt_diff[DIFF_W-1]}}, filt_diff};
            arith_preload   = ACC_W'({filt_ff, {FRAC_W{1'b0}}});
            arith_mult      = MLT_W'(filter_gain);
         end
         S_HMUL_GO: begin
            arith_cmd.start = 1'b1;
            arith_cmd.last  = COUNT_W'(SF_STEPS - 1);
            arith_operand   = ACC_W'(filt_ff[FILT_W-1:FRAC_W]);
            arith_mult      = MLT_W'(sound_factor);
         end
         S_HDIV_GO: begin
            // divide by 2000: drop 4 bits, then multiply by the reciprocal of 125
            arith_cmd.start = 1'b1;
            arith_cmd.last  = COUNT_W'(RECIP_STEPS - 1);
            arith_operand   = RECIP_125;
            arith_mult      = arith_acc[RECIP_PRESHIFT +: MLT_W];
         end
         default: ;
      endcase
   end

   uhlc_arith u_arith (
      .clock      (clock),
      .reset      (reset),
      .cmd        (arith_cmd),
      .operand    (arith_operand),
      .preload    (arith_preload),
      .multiplier (arith_mult),
      .stat       (arith_stat),
      .acc        (arith_acc)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (in_fire) begin
               state_in = (in_mode == MODE_ECHO) ? S_FILT_GO : S_EVAL;
            end
         end
         S_FILT_GO:   state_in = S_FILT_WAIT;
         S_FILT_WAIT: if (arith_stat.done) state_in = S_HMUL_GO;
         S_HMUL_GO:   state_in = S_HMUL_WAIT;
         S_HMUL_WAIT: if (arith_stat.done) state_in = S_HDIV_GO;
         S_HDIV_GO:   state_in = S_HDIV_WAIT;
         S_HDIV_WAIT: if (arith_stat.done) state_in = S_EVAL;
         S_EVAL:      if (out_free) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   // drive evaluation
   logic drive_up, drive_down, seek_next;

   always_comb begin
      drive_up   = 1'b0;
      drive_down = 1'b0;
      seek_next  = seek_ff;
      if (seek_ff) begin
         if (goal_ff > meas_ff) begin
            drive_up = 1'b1;
         end else if (goal_ff < meas_ff) begin
            drive_down = 1'b1;
         end else begin
            seek_next = 1'b0;
         end
      end else begin
         drive_up   = (manual_ff == DIR_UP);
         drive_down = (manual_ff == DIR_DOWN);
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         filt_ff      <= '0;
         meas_ff      <= HEIGHT_RESET;
         goal_ff      <= HEIGHT_RESET;
         seek_ff      <= 1'b0;
         manual_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         // result valid: load on evaluation, clear once taken
         if (state_ff == S_EVAL && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (in_fire) begin
                  case (in_mode)
                     MODE_GOTO: begin
                        goal_ff <= in_target;
                        seek_ff <= 1'b1;
                     end
                     MODE_PRESET: begin
                        goal_ff <= presets[in_preset];
                        seek_ff <= 1'b1;
                     end
                     MODE_MANUAL: begin
                        manual_ff <= in_dir;
                        seek_ff   <= 1'b0;
                     end
                     default: ;
                  endcase
               end
            end
            S_FILT_WAIT: begin
               if (arith_stat.done) begin
                  filt_ff <= arith_acc[FILT_W+FRAC_W-1:FRAC_W];
               end
            end
            S_HDIV_WAIT: begin
               if (arith_stat.done) begin
                  meas_ff <= (height_quot > HEIGHT_MAX) ? HEIGHT_MAX[HEIGHT_W-1:0]
                                                        : height_quot[HEIGHT_W-1:0];
               end
            end
            S_EVAL: begin
               if (out_free) begin
                  seek_ff <= seek_next;
               end
            end
            default: ;
         endcase
      end
   end

   // echo sample capture
   always_ff @(posedge clock) begin
      if (in_fire) begin
         echo_ff <= in_echo;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (state_ff == S_EVAL && out_free) begin
         rsp_data_ff <= {7'd0, seek_next, meas_ff, drive_down, drive_up};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ hdl/uhlc_checker.sv @@
// ----------------------------------------------------------------------------
// uhlc_checker
// Port-level checks of the lift height controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "ultrasonic_height_lift_control_macros.svh"

module uhlc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic [23:0] rsp_tdata
);

   // never drive both directions
   `UHLC_ASSERT_NEVER(a_motor_exclusive, clock, reset, rsp_tvalid && rsp_tdata[0] && rsp_tdata[1], "motor up and down together")

   // a result that still seeks must be moving
   `UHLC_ASSERT(a_seek_moves, clock, reset, (rsp_tvalid && rsp_tdata[16]) |-> (rsp_tdata[0] || rsp_tdata[1]), "seeking without drive")

   // one item at a time: busy right after an accepted transaction
   `UHLC_ASSERT(a_busy_after_accept, clock, reset, (req_tvalid && req_tready) |=> !req_tready, "ready right after accept")

   // a new result only comes out of a busy cycle
   `UHLC_ASSERT(a_result_from_work, clock, reset, $rose(rsp_tvalid) |-> $past(!req_tready), "result without work")

endmodule

bind ultrasonic_height_lift_control uhlc_checker u_checker (.*);
